>>> rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the page translation table.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int VA_W     = 64;
    localparam int OFS_W    = 12;
    localparam int VPAGE_W  = 52;
    localparam int PPAGE_W  = 24;
    localparam int CFG_W    = 25;
    localparam int PADDR_W  = 36;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] PPAGE_LIMIT = 25'h100_0000;

    localparam logic [OP_W-1:0] OP_TRANSLATE   = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOCATE    = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE        = 3'd2;
    localparam logic [OP_W-1:0] OP_FLUSH_ENTRY = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH_ALL   = 3'd4;
    localparam logic [OP_W-1:0] OP_RESET       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } ptt_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic cmp_pend;
        logic out_free;
    } ptt_stat_t;

endpackage

>>> rtl/page_translation_table.sv
// ----------------------------------------------------------------------------
// page_translation_table
// Fully associative 4 KiB page translation table with a bump page allocator.
// ----------------------------------------------------------------------------
// Input stream (s_*): s_tuser carries the op, s_tdata the virtual address.
// Output stream (m_*): m_tuser carries the status, m_tdata the physical
// address. Each input transfer yields exactly one output transfer, in order.
// APB port: register 0 at address 0 holds physical_pages (25 bits).
// Each item scans the table one entry per cycle through the single read
// port of the entry memory: each entry is read and then compared with the
// item's virtual page, the scan is left, and the commit writes the result
// into the output register.
// Items are handled one at a time; a new item is accepted once the previous
// one is committed, even while its result still waits in the output register.
// While the output register holds a result and m_tready is low, the commit
// waits and the table is not changed until the output register is free.
// rst_n clears the valid bits, the page count, physical_pages and m_tvalid at
// once and returns the sequencer to idle; entry contents are left as they are.
// ----------------------------------------------------------------------------
module page_translation_table #(
    parameter int TABLE_ENTRIES = ptt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] virtual_address
    input  logic [2:0]  s_tuser,   // [2:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [35:0] physical_address, [39:36] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ptt_pkg::*;

    localparam logic REG_PHYS_PAGES = 1'b0;

    ptt_cmd_t  cmd;
    ptt_stat_t stat;

    logic [CFG_W-1:0]   pages_reg;
    logic [PADDR_W-1:0] out_addr;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_PHYS_PAGES))
        begin
            pages_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_PHYS_PAGES) ? {{(32-CFG_W){1'b0}}, pages_reg} : '0;

    ptt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_va      (s_tdata),
        .cfg_pages  (pages_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_addr   (out_addr)
    );

    assign m_tdata = {4'b0, out_addr};

endmodule

>>> rtl/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer: accepts an item, steps the table scan, commits the result.
// ----------------------------------------------------------------------------
module ptt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ptt_pkg::ptt_stat_t stat,
    output ptt_pkg::ptt_cmd_t  cmd
);
    import ptt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_end && !stat.cmp_pend)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.start  = 1'b0;
        cmd.scan   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            S_SCAN:
            begin
                cmd.scan = !stat.scan_end;
            end
            S_FINISH:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

    a_start_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == S_SCAN)
        else $error("accepted transfer did not start a scan");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free && !stat.cmp_pend)
        else $error("commit while output busy or compare pending");

    a_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> state_reg == S_SCAN && !s_tready)
        else $error("scan read outside scan state");

endmodule

>>> rtl/ptt_datapath.sv
// ----------------------------------------------------------------------------
// ptt_datapath
// Entry memory, valid bits, page counter, scan compare and output register.
// ----------------------------------------------------------------------------
module ptt_datapath #(
    parameter int TABLE_ENTRIES = ptt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptt_pkg::ptt_cmd_t             cmd,
    output ptt_pkg::ptt_stat_t            stat,
    input  logic [ptt_pkg::OP_W-1:0]      in_op,
    input  logic [ptt_pkg::VA_W-1:0]      in_va,
    input  logic [ptt_pkg::CFG_W-1:0]     cfg_pages,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ptt_pkg::STATUS_W-1:0]  out_status,
    output logic [ptt_pkg::PADDR_W-1:0]   out_addr
);
    import ptt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic [VPAGE_W-1:0] vpage_mem [TABLE_ENTRIES];
    logic [PPAGE_W-1:0] ppage_mem [TABLE_ENTRIES];

    logic [OP_W-1:0]          op_reg;
    logic [VA_W-1:0]          va_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [VPAGE_W-1:0]       vp_rd_reg;
    logic [PPAGE_W-1:0]       pp_rd_reg;
    logic                     cmp_pend_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [PPAGE_W-1:0]       hit_pp_reg;
    logic                     free_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [CFG_W-1:0]         count_reg;
    logic [CFG_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic [PADDR_W-1:0]       addr_reg;
    logic [PADDR_W-1:0]       addr_next;

    logic [VPAGE_W-1:0] item_vpage;
    logic               cmp_valid;
    logic               cmp_match;
    logic [CFG_W-1:0]   limit;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;

    assign item_vpage = va_reg[VA_W-1:OFS_W];
    assign cmp_valid  = valid_reg[cmp_idx_reg];
    assign cmp_match  = cmp_valid && (vp_rd_reg == item_vpage);
    assign limit      = cfg_pages[CFG_W-1] ? PPAGE_LIMIT : cfg_pages;

    assign stat.scan_end = (cnt_reg == CNT_W'(TABLE_ENTRIES));
    assign stat.cmp_pend = cmp_pend_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg <= in_op;
            va_reg <= in_va;
        end
    end

    // entry memory: scan read port, commit write port
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            vp_rd_reg <= vpage_mem[cnt_reg[IDX_W-1:0]];
            pp_rd_reg <= ppage_mem[cnt_reg[IDX_W-1:0]];
        end
        if (wr_en)
        begin
            vpage_mem[wr_idx] <= item_vpage;
            ppage_mem[wr_idx] <= count_reg[PPAGE_W-1:0];
        end
    end

    // scan bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            cmp_pend_reg <= 1'b0;
            cmp_idx_reg  <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
        end
        else
        begin
            cmp_pend_reg <= cmd.scan;
            if (cmd.start)
            begin
                cnt_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    cnt_reg     <= cnt_reg + CNT_W'(1);
                    cmp_idx_reg <= cnt_reg[IDX_W-1:0];
                end
                if (cmp_pend_reg && cmp_match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmp_pend_reg && !cmp_valid && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_pend_reg && cmp_match && !hit_reg)
        begin
            hit_idx_reg <= cmp_idx_reg;
            hit_pp_reg  <= pp_rd_reg;
        end
        if (cmp_pend_reg && !cmp_valid && !free_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    // commit
    always_comb
    begin
        valid_next  = valid_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        addr_next   = '0;
        wr_en       = 1'b0;
        wr_idx      = hit_reg ? hit_idx_reg : free_idx_reg;
        case (op_reg)
            OP_TRANSLATE:
            begin
                if (hit_reg)
                begin
                    addr_next = {hit_pp_reg, va_reg[OFS_W-1:0]};
                end
                else
                begin
                    status_next = ST_UNMAPPED;
                end
            end
            OP_ALLOCATE:
            begin
                if (({1'b0, count_reg} + (CFG_W+1)'(1)) > {1'b0, limit})
                begin
                    status_next = ST_NO_MEMORY;
                end
                else if (!hit_reg && !free_reg)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en              = 1'b1;
                    valid_next[wr_idx] = 1'b1;
                    addr_next          = {count_reg[PPAGE_W-1:0], {OFS_W{1'b0}}};
                    count_next         = count_reg + CFG_W'(1);
                end
            end
            OP_FREE:
            begin
                if (hit_reg)
                begin
                    valid_next[hit_idx_reg] = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CFG_W'(1);
                    end
                end
                else
                begin
                    status_next = ST_UNMAPPED;
                end
            end
            OP_FLUSH_ENTRY:
            begin
                if (hit_reg)
                begin
                    valid_next[hit_idx_reg] = 1'b0;
                end
                else
                begin
                    status_next = ST_UNMAPPED;
                end
            end
            OP_FLUSH_ALL:
            begin
                valid_next = '0;
            end
            OP_RESET:
            begin
                valid_next = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
        if (!cmd.commit)
        begin
            wr_en      = 1'b0;
            valid_next = valid_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= status_next;
            addr_reg   <= addr_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_addr   = addr_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PPAGE_LIMIT)
        else $error("page count above physical page limit");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_hit_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && hit_reg |-> valid_reg[hit_idx_reg])
        else $error("hit entry is not valid at commit");

endmodule
